/* rtl/rb2d_pkg.sv */
// Shared types, opcodes and helpers for the 2D rigid body step core.
// No dependencies; used by rb2d_iter_unit and rigid_body_2d_step_core.
package rb2d_pkg;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic        start;
    iter_op_t    op;
    logic [63:0] a;   // dividend or radicand
    logic [31:0] d;   // divisor
  } iter_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } iter_rsp_t;

  localparam logic [1:0] REG_MASS     = 2'd0;
  localparam logic [1:0] REG_FRICTION = 2'd1;
  localparam logic [1:0] REG_MAXSPEED = 2'd2;

  localparam logic [31:0] MASS_RESET     = 32'd65536;
  localparam logic [31:0] FRICTION_RESET = 32'd6553600;
  localparam logic [31:0] MAXSPEED_RESET = 32'd13107200;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [49:0] s);
    if (s > 50'sd2147483647) begin
      sat32 = 32'h7fff_ffff;
    end else if (s < -50'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = s[31:0];
    end
  endfunction

  function automatic logic signed [49:0] sext50(input logic [31:0] v);
    sext50 = $signed({{18{v[31]}}, v});
  endfunction

  // sign-applied magnitude: neg ? -m : m
  function automatic logic signed [49:0] signed_mag(input logic neg,
                                                    input logic [47:0] m);
    logic signed [49:0] t;
    t = $signed({2'b00, m});
    signed_mag = neg ? -t : t;
  endfunction

endpackage

/* rtl/rb2d_iter_unit.sv */
// Shared iterative unit: restoring divide (64/32, one quotient bit per cycle)
// and integer square root (64-bit radicand, one root bit per cycle).
// Depends on rb2d_pkg.
module rb2d_iter_unit (
  input  logic                clk,
  input  logic                rst,
  input  rb2d_pkg::iter_req_t req,
  output rb2d_pkg::iter_rsp_t rsp
);

  localparam logic [6:0] DivSteps  = 7'd64;
  localparam logic [6:0] SqrtSteps = 7'd32;

  logic [63:0]        acc;
  logic [34:0]        rem;
  logic [31:0]        root;
  logic [31:0]        dvs;
  logic [6:0]         cnt;
  logic               done;
  rb2d_pkg::iter_op_t op_r;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;

  always_comb begin
    if (op_r == rb2d_pkg::OP_DIV) begin
      rem_sh = {rem[33:0], acc[63]};
      trial  = {3'b000, dvs};
    end else begin
      rem_sh = {rem[32:0], acc[63:62]};
      trial  = {1'b0, root, 2'b01};
    end
    ge = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
      op_r <= rb2d_pkg::OP_DIV;
    end else if (req.start) begin
      acc  <= req.a;
      rem  <= '0;
      root <= '0;
      dvs  <= req.d;
      op_r <= req.op;
      cnt  <= (req.op == rb2d_pkg::OP_DIV) ? DivSteps : SqrtSteps;
      done <= 1'b0;
    end else if (cnt != 7'd0) begin
      rem <= ge ? (rem_sh - trial) : rem_sh;
      if (op_r == rb2d_pkg::OP_DIV) begin
        acc <= {acc[62:0], ge};
      end else begin
        acc  <= {acc[61:0], 2'b00};
        root <= {root[30:0], ge};
      end
      cnt  <= cnt - 7'd1;
      done <= (cnt == 7'd1);
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.busy   = (cnt != 7'd0);
  assign rsp.done   = done;
  assign rsp.result = (op_r == rb2d_pkg::OP_DIV) ? acc : {32'd0, root};

endmodule

/* rtl/rigid_body_2d_step_core.sv */
// 2D rigid body step: force integration, friction, speed clamp, position step.
// Depends on rb2d_pkg and rb2d_iter_unit.
//
//   channel  signals                                 dir  handshake
//   in       force_x force_y pos_x pos_y dt          in   in_valid / in_ready
//   out      new_pos_x new_pos_y speed_x speed_y     out  out_valid / out_ready
//   cfg      cfg_we cfg_index cfg_data               in   write strobe, no wait
//
// An item finishes soonest at zero velocity and takes longest when friction
// and clamp both scale; the 64-step shared divider sets most of that time.
// in_ready is high only in idle; one finished result waits in the output
// register while the next item is accepted and worked on.
// Reset restores register defaults and clears the stored velocity.
module rigid_body_2d_step_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] force_x,
  input  logic [31:0] force_y,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [15:0] dt,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] new_pos_x,
  output logic [31:0] new_pos_y,
  output logic [31:0] speed_x,
  output logic [31:0] speed_y,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_FMUL, S_FDIV, S_FWAIT, S_FRIC, S_FRN, S_SQX, S_SQY, S_SQS,
    S_SQW, S_SPD, S_SMUL, S_SDIV, S_SWAIT, S_PMUL, S_PADD, S_DONE
  } state_t;

  state_t      state;
  logic [31:0] mass, friction_coeff, max_speed;
  logic [31:0] fx, fy, px, py;
  logic [15:0] dt_r;
  logic [31:0] vx, vy;
  logic [31:0] fr, spd;
  logic [63:0] sqx, prod;
  logic        ax, clamp_ph;

  logic [31:0] mul_a, mul_b;
  logic [31:0] cur_v, cur_f, cur_p;
  logic [31:0] nv_force, nv_scale, np;
  logic [31:0] q32;

  rb2d_pkg::iter_req_t req;
  rb2d_pkg::iter_rsp_t rsp;

  rb2d_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign cur_v = ax ? vy : vx;
  assign cur_f = ax ? fy : fx;
  assign cur_p = ax ? py : px;
  assign q32   = rsp.result[31:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_FMUL: begin
        mul_a = rb2d_pkg::abs32(cur_f);
        mul_b = {16'd0, dt_r};
      end
      S_FRIC: begin
        mul_a = friction_coeff;
        mul_b = {16'd0, dt_r};
      end
      S_SQX: begin
        mul_a = rb2d_pkg::abs32(vx);
        mul_b = rb2d_pkg::abs32(vx);
      end
      S_SQY: begin
        mul_a = rb2d_pkg::abs32(vy);
        mul_b = rb2d_pkg::abs32(vy);
      end
      S_SMUL: begin
        mul_a = rb2d_pkg::abs32(cur_v);
        mul_b = clamp_ph ? max_speed : fr;
      end
      S_PMUL: begin
        mul_a = rb2d_pkg::abs32(cur_v);
        mul_b = {16'd0, dt_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    req.start = 1'b0;
    req.op    = rb2d_pkg::OP_DIV;
    req.a     = prod;
    req.d     = spd;
    case (state)
      S_FDIV: begin
        req.start = 1'b1;
        req.d     = (mass == 32'd0) ? 32'd1 : mass;
      end
      S_SQS: begin
        req.start = 1'b1;
        req.op    = rb2d_pkg::OP_SQRT;
        req.a     = sqx + prod;
      end
      S_SDIV: begin
        req.start = 1'b1;
      end
      default: ;
    endcase
  end

  assign nv_force = rb2d_pkg::sat32(rb2d_pkg::sext50(cur_v)
                      + rb2d_pkg::signed_mag(cur_f[31], rsp.result[47:0]));
  // friction removes a share of each axis; clamp replaces it
  assign nv_scale = clamp_ph
                  ? (cur_v[31] ? (32'd0 - q32) : q32)
                  : (cur_v - (cur_v[31] ? (32'd0 - q32) : q32));
  assign np = rb2d_pkg::sat32(rb2d_pkg::sext50(cur_p)
                + rb2d_pkg::signed_mag(cur_v[31], {16'd0, prod[47:16]}));

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      vx             <= '0;
      vy             <= '0;
      ax             <= 1'b0;
      clamp_ph       <= 1'b0;
      mass           <= rb2d_pkg::MASS_RESET;
      friction_coeff <= rb2d_pkg::FRICTION_RESET;
      max_speed      <= rb2d_pkg::MAXSPEED_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rb2d_pkg::REG_MASS:     mass           <= cfg_data;
          rb2d_pkg::REG_FRICTION: friction_coeff <= cfg_data;
          rb2d_pkg::REG_MAXSPEED: max_speed      <= cfg_data;
          default: ;
        endcase
      end
      // the done state reloads the output register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            fx    <= force_x;
            fy    <= force_y;
            px    <= pos_x;
            py    <= pos_y;
            dt_r  <= dt;
            ax    <= 1'b0;
            state <= S_FMUL;
          end
        end
        S_FMUL: state <= S_FDIV;
        S_FDIV: state <= S_FWAIT;
        S_FWAIT: begin
          if (rsp.done) begin
            if (ax) vy <= nv_force;
            else    vx <= nv_force;
            ax    <= ~ax;
            state <= ax ? S_FRIC : S_FMUL;
          end
        end
        S_FRIC: begin
          clamp_ph <= 1'b0;
          // a body at rest gets no friction and cannot exceed the limit
          state    <= (vx == 32'd0 && vy == 32'd0) ? S_PMUL : S_FRN;
        end
        S_FRN: begin
          fr    <= prod[47:16];
          state <= S_SQX;
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          sqx   <= prod;
          state <= S_SQS;
        end
        S_SQS: state <= S_SQW;
        S_SQW: begin
          if (rsp.done) begin
            spd   <= q32;
            state <= S_SPD;
          end
        end
        S_SPD: begin
          if (!clamp_ph) begin
            if (fr >= spd) begin
              vx    <= '0;
              vy    <= '0;
              state <= S_PMUL;
            end else begin
              state <= S_SMUL;
            end
          end else begin
            state <= (spd > max_speed) ? S_SMUL : S_PMUL;
          end
        end
        S_SMUL: state <= S_SDIV;
        S_SDIV: state <= S_SWAIT;
        S_SWAIT: begin
          if (rsp.done) begin
            if (ax) vy <= nv_scale;
            else    vx <= nv_scale;
            ax <= ~ax;
            if (!ax) begin
              state <= S_SMUL;
            end else if (!clamp_ph) begin
              clamp_ph <= 1'b1;
              state    <= S_SQX;
            end else begin
              state <= S_PMUL;
            end
          end
        end
        S_PMUL: state <= S_PADD;
        S_PADD: begin
          if (ax) py <= np;
          else    px <= np;
          ax    <= ~ax;
          state <= ax ? S_DONE : S_PMUL;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            new_pos_x <= px;
            new_pos_y <= py;
            speed_x   <= vx;
            speed_y   <= vy;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_unit_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rsp.busy)
    else $error("iterative unit busy while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_FMUL))
    else $error("accepted item did not start");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_FWAIT || state == S_SQW || state == S_SWAIT))
    else $error("unit result arrived outside a wait state");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !rsp.busy)
    else $error("unit restarted while busy");

endmodule

/* bench/rigid_body_2d_step_core_tb.sv */
// Self-checking bench for rigid_body_2d_step_core: random and directed frame ticks,
// bursty sender, stalling receiver, in-bench fixed-point predictor of the motion step.
// Depends on rb2d_pkg and the core RTL.
module rigid_body_2d_step_core_tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 600;

  typedef struct {
    logic [31:0] fx, fy, px, py;
    logic [15:0] dt;
  } tick_t;

  typedef struct {
    logic [31:0] npx, npy, vx, vy;
  } motion_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [31:0] force_x = 0, force_y = 0, pos_x = 0, pos_y = 0;
  logic [15:0] dt = 0;
  logic [31:0] new_pos_x, new_pos_y, speed_x, speed_y;
  logic cfg_we = 0;
  logic [1:0] cfg_index = rb2d_pkg::REG_MASS;
  logic [31:0] cfg_data = 0;

  rigid_body_2d_step_core uut (.*);

  always #10 clk = ~clk;

  // predictor state and register shadows
  logic [31:0] mass_r, fric_r, vmax_r;
  logic signed [31:0] vel_x_m, vel_y_m;

  tick_t pending_ticks[$];
  motion_t expected_motion[$];
  int errors = 0;
  int received = 0;
  int cycles = 0;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // sign(v) * floor(|v| * num / den)
  function automatic logic signed [63:0] scale_s(logic signed [63:0] v, logic [63:0] num,
                                                 logic [63:0] den);
    logic [63:0] a, q;
    a = v < 0 ? -v : v;
    q = (a * num) / den;
    return v < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] clip32(logic signed [63:0] s);
    if (s > 64'sd2147483647) return 32'h7fff_ffff;
    if (s < -64'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  function automatic logic [63:0] speed_of(logic signed [31:0] x, logic signed [31:0] y);
    logic [63:0] ax, ay;
    ax = x < 0 ? -64'(x) : 64'(x);
    ay = y < 0 ? -64'(y) : 64'(y);
    return root64(ax * ax + ay * ay);
  endfunction

  function automatic motion_t step_body(tick_t t);
    logic [63:0] m, fr, spd, dtu;
    logic signed [31:0] vx, vy;
    motion_t o;
    dtu = 64'(t.dt);
    m = (mass_r == 0) ? 64'd1 : 64'(mass_r);
    vx = clip32(64'(vel_x_m) + scale_s(64'($signed(t.fx)), dtu, m));
    vy = clip32(64'(vel_y_m) + scale_s(64'($signed(t.fy)), dtu, m));
    if (vx != 0 || vy != 0) begin
      fr = (64'(fric_r) * dtu) >> 16;
      spd = speed_of(vx, vy);
      if (fr >= spd) begin
        vx = 0;
        vy = 0;
      end else begin
        vx = 32'(64'(vx) - scale_s(64'(vx), fr, spd));
        vy = 32'(64'(vy) - scale_s(64'(vy), fr, spd));
      end
    end
    spd = speed_of(vx, vy);
    if (spd > 64'(vmax_r)) begin
      vx = 32'(scale_s(64'(vx), 64'(vmax_r), spd));
      vy = 32'(scale_s(64'(vy), 64'(vmax_r), spd));
    end
    vel_x_m = vx;
    vel_y_m = vy;
    o.npx = clip32(64'($signed(t.px)) + scale_s(64'(vx), dtu, 64'd65536));
    o.npy = clip32(64'($signed(t.py)) + scale_s(64'(vy), dtu, 64'd65536));
    o.vx = vx;
    o.vy = vy;
    return o;
  endfunction

  function automatic logic [31:0] rand_force();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
      default: return 32'($signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.fx = rand_force();
    t.fy = $urandom_range(0, 5) == 0 ? 32'd0 : rand_force();
    t.px = $urandom();
    t.py = $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 2000000)) - 1000000);
    case ($urandom_range(0, 4))
      0: t.dt = 16'($urandom());
      1: t.dt = 16'd0;
      default: t.dt = 16'($urandom_range(1, 2000));
    endcase
    return t;
  endfunction

  function automatic tick_t mk(logic [31:0] fx, fy, px, py, logic [15:0] d);
    tick_t t;
    t.fx = fx; t.fy = fy; t.px = px; t.py = py; t.dt = d;
    return t;
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_motion.push_back(step_body(mk(force_x, force_y, pos_x, pos_y, dt)));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          tick_t t;
          t = pending_ticks.pop_front();
          force_x <= t.fx; force_y <= t.fy; pos_x <= t.px; pos_y <= t.py; dt <= t.dt;
          in_valid <= 1'b1;
          if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int hold_left = 0;
  bit held = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (!rst) begin
      if (out_valid && out_ready) begin
        motion_t e;
        received++;
        if (expected_motion.size() == 0) begin
          errors++;
          $display("%0t: unexpected item pos=(%h,%h) vel=(%h,%h)", $realtime,
                   new_pos_x, new_pos_y, speed_x, speed_y);
        end else begin
          e = expected_motion.pop_front();
          if (e.npx !== new_pos_x || e.npy !== new_pos_y ||
              e.vx !== speed_x || e.vy !== speed_y) begin
            errors++;
            $display("%0t: mismatch expected pos=(%h,%h) vel=(%h,%h) got pos=(%h,%h) vel=(%h,%h)",
                     $realtime, e.npx, e.npy, e.vx, e.vy,
                     new_pos_x, new_pos_y, speed_x, speed_y);
          end
        end
      end
      if (!held && received == 100) begin
        held = 1;
        hold_left = 4000;
      end
      if (hold_left > 0) hold_left--;
      out_ready <= (hold_left == 0) &&
                   (((cycles / 700) % 2 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0));
    end
  end

  task automatic drain();
    while (pending_ticks.size() > 0 || in_valid || expected_motion.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      rb2d_pkg::REG_MASS: mass_r = val;
      rb2d_pkg::REG_FRICTION: fric_r = val;
      default: vmax_r = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_random(int n);
    repeat (n) pending_ticks.push_back(rand_tick());
  endtask

  initial begin
    mass_r = rb2d_pkg::MASS_RESET;
    fric_r = rb2d_pkg::FRICTION_RESET;
    vmax_r = rb2d_pkg::MAXSPEED_RESET;
    vel_x_m = 0; vel_y_m = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: idle body, extremes, zero dt, friction stop, clamp
    pending_ticks.push_back(mk(0, 0, 32'h1234_5678, 32'hfedc_ba98, 16'h1000));
    pending_ticks.push_back(mk(32'h7fff_ffff, 0, 0, 0, 16'hffff));
    pending_ticks.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hffff));
    pending_ticks.push_back(mk(0, 0, 32'h7fff_ffff, 32'h8000_0000, 16'hffff));
    pending_ticks.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 16'd0));
    pending_ticks.push_back(mk(32'h0100_0000, 32'hff00_0000, 5, 6, 16'd1092));
    pending_ticks.push_back(mk(0, 0, 0, 0, 16'd1092));
    pending_ticks.push_back(mk(32'h0001_0000, 0, 0, 0, 16'd1));
    pending_ticks.push_back(mk(32'h0320_0000, 32'h0320_0000, 32'h7fff_0000, 32'h8001_0000, 16'd800));
    pending_ticks.push_back(mk(0, 0, 0, 0, 16'd0));
    pending_ticks.push_back(mk(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 1, 16'h8000));
    pending_ticks.push_back(mk(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 16'h5555));
    pending_ticks.push_back(mk(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa, 16'haaaa));
    add_random(450);
    drain();

    // light body, no friction, no limit: saturation
    write_reg(rb2d_pkg::REG_MASS, 32'd1);
    write_reg(rb2d_pkg::REG_FRICTION, 32'd0);
    write_reg(rb2d_pkg::REG_MAXSPEED, 32'hffff_ffff);
    add_random(150);
    drain();

    // heavy body, maximum friction, zero speed limit
    write_reg(rb2d_pkg::REG_MASS, 32'hffff_ffff);
    write_reg(rb2d_pkg::REG_FRICTION, 32'hffff_ffff);
    write_reg(rb2d_pkg::REG_MAXSPEED, 32'd0);
    add_random(150);
    drain();

    // zero mass register treated as one LSB
    write_reg(rb2d_pkg::REG_MASS, 32'd0);
    write_reg(rb2d_pkg::REG_FRICTION, $urandom_range(0, 32'h0100_0000));
    write_reg(rb2d_pkg::REG_MAXSPEED, $urandom());
    add_random(300);
    drain();

    write_reg(rb2d_pkg::REG_MASS, $urandom_range(32'h4000, 32'h40_0000));
    write_reg(rb2d_pkg::REG_FRICTION, $urandom_range(0, 32'h0080_0000));
    write_reg(rb2d_pkg::REG_MAXSPEED, $urandom_range(32'h10000, 32'h4000_0000));
    add_random(500);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
